[rtl/xef_pkg.sv]
`timescale 1ns / 1ps
// xef_pkg: shared types, codes and lookup functions for the xml escape filter
// no dependencies; imported by every module of the block

package xef_pkg;

    localparam int MaxPendingDef = 19;
    localparam int LenW          = 6;
    localparam int QDepth        = 4;

    localparam logic [7:0] ChAmp   = 8'h26;
    localparam logic [7:0] ChLt    = 8'h3C;
    localparam logic [7:0] ChGt    = 8'h3E;
    localparam logic [7:0] ChQuot  = 8'h22;
    localparam logic [7:0] ChApos  = 8'h27;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChSpace = 8'h20;

    typedef enum logic [1:0] {
        ASC_NONE,
        ASC_PLAIN,
        ASC_ENT
    } t_asc;

    typedef enum logic [2:0] {
        ENT_AMP,
        ENT_LT,
        ENT_GT,
        ENT_QUOT,
        ENT_APOS
    } t_ent;

    typedef struct packed {
        logic            run_emit;
        logic            run_bank;
        logic [LenW-1:0] run_len;
        t_asc            asc_kind;
        t_ent            ent_id;
        logic [7:0]      asc_byte;
    } t_op;

    typedef struct packed {
        logic            en;
        logic            bank;
        logic [LenW-1:0] idx;
        logic [7:0]      data;
    } t_wr;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    function automatic logic [2:0] implied_len(input logic [7:0] lead);
        logic [2:0] len;
        if (!lead[5]) begin
            len = 3'd2;
        end else if (!lead[4]) begin
            len = 3'd3;
        end else if (!lead[3]) begin
            len = 3'd4;
        end else if (!lead[2]) begin
            len = 3'd5;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    function automatic logic [2:0] ent_len(input t_ent id);
        logic [2:0] len;
        unique case (id)
            ENT_AMP:  len = 3'd5;
            ENT_LT:   len = 3'd4;
            ENT_GT:   len = 3'd4;
            ENT_QUOT: len = 3'd6;
            ENT_APOS: len = 3'd6;
            default:  len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] ent_char(input t_ent id, input logic [2:0] pos);
        logic [47:0] s;
        unique case (id)
            ENT_AMP:  s = {"&amp;", 8'h00};
            ENT_LT:   s = {"&lt;", 16'h0000};
            ENT_GT:   s = {"&gt;", 16'h0000};
            ENT_QUOT: s = "&quot;";
            ENT_APOS: s = "&apos;";
            default:  s = '0;
        endcase
        return s[(5 - int'(pos)) * 8 +: 8];
    endfunction

endpackage

[rtl/xef_front.sv]
`timescale 1ns / 1ps
// xef_front: accepts input transactions, classifies bytes and tracks the pending run
// depends on xef_pkg; writes the run store in xef_back and pushes ops into xef_queue

module xef_front #(
    parameter int MAX_PENDING = xef_pkg::MaxPendingDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_cmd,
    input  logic [7:0]     i_byte,
    output logic           o_ready,
    input  logic           i_q_full,
    output logic           o_push,
    output xef_pkg::t_op   o_op,
    output xef_pkg::t_wr   o_wr,
    input  xef_pkg::t_rel  i_rel
);
    import xef_pkg::*;

    localparam int CW = $clog2(MAX_PENDING + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_bank, n_bank;
    logic [1:0]    r_busy, n_busy;
    logic [7:0]    r_lead, n_lead;

    logic       accept, is_ascii, is_lead, is_cont, flush, run_ok;
    logic [2:0] want;
    t_op        op;
    t_wr        wr;

    assign o_ready  = !i_q_full && !r_busy[!r_bank];
    assign accept   = i_valid && o_ready;
    assign is_ascii = !i_cmd && !i_byte[7];
    assign is_lead  = !i_cmd && (i_byte[7:6] == 2'b11);
    assign is_cont  = !i_cmd && (i_byte[7:6] == 2'b10);
    assign flush    = !is_cont;
    assign want     = implied_len(r_lead);
    assign run_ok   = (r_count != '0) && ((want == 3'd0) || (CW'(want) == r_count));

    always_comb begin
        op          = '0;
        op.run_emit = run_ok && flush;
        op.run_bank = r_bank;
        op.run_len  = LenW'(r_count);
        op.asc_kind = ASC_NONE;
        op.ent_id   = ENT_AMP;
        op.asc_byte = i_byte;
        if (is_ascii) begin
            case (i_byte)
                ChAmp: begin
                    op.asc_kind = ASC_ENT;
                    op.ent_id   = ENT_AMP;
                end
                ChLt: begin
                    op.asc_kind = ASC_ENT;
                    op.ent_id   = ENT_LT;
                end
                ChGt: begin
                    op.asc_kind = ASC_ENT;
                    op.ent_id   = ENT_GT;
                end
                ChQuot: begin
                    op.asc_kind = ASC_ENT;
                    op.ent_id   = ENT_QUOT;
                end
                ChApos: begin
                    op.asc_kind = ASC_ENT;
                    op.ent_id   = ENT_APOS;
                end
                ChTab, ChLf, ChCr: begin
                    op.asc_kind = ASC_PLAIN;
                    op.asc_byte = ChSpace;
                end
                default: begin
                    if (i_byte >= ChSpace) begin
                        op.asc_kind = ASC_PLAIN;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        n_bank  = r_bank;
        n_busy  = r_busy;
        n_lead  = r_lead;
        wr      = '0;
        wr.data = i_byte;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (accept) begin
            if (flush) begin
                n_count = '0;
                if (op.run_emit) begin
                    n_busy[r_bank] = 1'b1;
                    n_bank         = !r_bank;
                end
                if (is_lead) begin
                    n_count = CW'(1);
                    n_lead  = i_byte;
                    wr.en   = 1'b1;
                    wr.bank = n_bank;
                    wr.idx  = '0;
                end
            end else if (r_count != '0) begin
                if (r_count >= CW'(MAX_PENDING)) begin
                    n_count = '0;
                end else begin
                    wr.en   = 1'b1;
                    wr.bank = r_bank;
                    wr.idx  = LenW'(r_count);
                    n_count = r_count + CW'(1);
                end
            end
        end
    end

    assign o_push = accept && flush && (op.run_emit || (op.asc_kind != ASC_NONE));
    assign o_op   = op;
    assign o_wr   = wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bank  <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_count <= n_count;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lead <= n_lead;
    end

    // the bank being filled is never one still owed to the back end
    a_fill_bank_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy[r_bank])
        else $error("front is filling a bank the back end still reads");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PENDING))
        else $error("pending count beyond store depth");

endmodule

[rtl/xef_queue.sv]
`timescale 1ns / 1ps
// xef_queue: short fifo of classified ops between the front and back ends
// depends on xef_pkg for the op type and depth

module xef_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xef_pkg::t_op  i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output xef_pkg::t_op  o_op
);
    import xef_pkg::*;

    localparam int PW = $clog2(QDepth);

    t_op         r_q [QDepth];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW + 1)'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (PW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_op;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty op queue");

endmodule

[rtl/xef_back.sv]
`timescale 1ns / 1ps
// xef_back: holds the two-bank run store and emits run bytes and escaped text
// depends on xef_pkg; fed by xef_queue and written by xef_front

module xef_back #(
    parameter int MAX_PENDING = xef_pkg::MaxPendingDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  xef_pkg::t_op   i_op,
    output logic           o_pop,
    input  xef_pkg::t_wr   i_wr,
    output xef_pkg::t_rel  o_rel,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_last
);
    import xef_pkg::*;

    localparam int IW = $clog2(MAX_PENDING);
    localparam int AW = IW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_RUNO,
        S_ASC
    } t_state;

    logic [7:0]      r_mem [2**AW];
    logic [7:0]      r_rdata;
    logic [AW-1:0]   rd_addr;

    t_state          r_state, n_state;
    logic [LenW-1:0] r_idx, n_idx;
    logic [2:0]      r_pos, n_pos;
    logic            r_ovalid, n_ovalid;
    logic [7:0]      r_obyte, n_obyte;
    logic            r_olast, n_olast;

    logic can_load, run_end, ent_end;
    t_rel rel;

    assign rd_addr  = {i_op.run_bank, r_idx[IW-1:0]};
    assign can_load = !r_ovalid || i_ready;
    assign run_end  = (r_idx == (i_op.run_len - LenW'(1)));
    assign ent_end  = (r_pos == (ent_len(i_op.ent_id) - 3'd1));

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.idx[IW-1:0]}] <= i_wr.data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        o_pop    = 1'b0;
        rel      = '0;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_idx   = '0;
                    n_pos   = '0;
                    n_state = i_op.run_emit ? S_RD : S_ASC;
                end
            end
            S_RD: begin
                n_state = S_RUNO;
            end
            S_RUNO: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_obyte  = r_rdata;
                    n_olast  = run_end && (i_op.asc_kind == ASC_NONE);
                    if (run_end) begin
                        rel.valid = 1'b1;
                        rel.bank  = i_op.run_bank;
                        n_pos     = '0;
                        if (i_op.asc_kind == ASC_NONE) begin
                            o_pop   = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_ASC;
                        end
                    end else begin
                        n_idx   = r_idx + LenW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_ASC: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    if (i_op.asc_kind == ASC_ENT) begin
                        n_obyte = ent_char(i_op.ent_id, r_pos);
                        n_olast = ent_end;
                    end else begin
                        n_obyte = i_op.asc_byte;
                        n_olast = 1'b1;
                    end
                    if (n_olast) begin
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    assign o_rel   = rel;
    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;

    // the op at the queue head stays put while it is being worked on
    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> i_q_valid)
        else $error("op left the queue while in progress");

    // retiring an op always goes with loading its final byte
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_ovalid && r_olast))
        else $error("op retired without a final byte");

endmodule

[rtl/xml_escape_utf8_filter.sv]
`timescale 1ns / 1ps
// xml_escape_utf8_filter: top level of the xml escape and utf-8 run filter
// depends on xef_pkg, xef_front, xef_queue and xef_back
//
// Usage
//   Input channel i_in_valid / o_in_ready carries i_cmd and i_in_byte. With
//   i_cmd low a text byte is taken; with i_cmd high the pending multibyte run
//   is flushed and i_in_byte is ignored.
//   Output channel o_out_valid / i_out_ready carries o_out_byte, with
//   o_last_of_run high on the final output byte caused by one input.
//   An input that causes no output produces no output transaction.
//   The first output byte passes through the op queue and the output register,
//   a flushed run also through the registered read of the two-bank run store.
//   Further bytes of an entity follow at one byte per cycle while the receiver
//   accepts them; each byte of a flushed utf-8 run waits for its own read of
//   the run store, and the output sequencer passes through idle between ops.
//   A four-entry op queue lets input continue while output is stalled; input
//   also waits while a previously flushed run is still being read out of the
//   other store bank.
//   Reset (i_rst_n low, synchronous) empties the queue, drops any pending run
//   and clears the output valid flag. When the receiver stalls, the output byte
//   holds and the queue absorbs up to four further producing inputs.

module xml_escape_utf8_filter #(
    parameter int MAX_PENDING = xef_pkg::MaxPendingDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);
    import xef_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    t_op  op_in, op_head;
    t_wr  wr;
    t_rel rel;

    xef_front #(
        .MAX_PENDING(MAX_PENDING)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_cmd    (i_cmd),
        .i_byte   (i_in_byte),
        .o_ready  (o_in_ready),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_op     (op_in),
        .o_wr     (wr),
        .i_rel    (rel)
    );

    xef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (op_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (op_head)
    );

    xef_back #(
        .MAX_PENDING(MAX_PENDING)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (op_head),
        .o_pop     (q_pop),
        .i_wr      (wr),
        .o_rel     (rel),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_byte    (o_out_byte),
        .o_last    (o_last_of_run)
    );

endmodule
